// ----- design/satb_pkg.sv -----
package satb_pkg;

  // Proximity scale: the beep period moves linearly over this RSSI window.
  localparam int RSSI_FAR  = -90;
  localparam int RSSI_NEAR = -30;
  localparam int RSSI_SPAN = RSSI_NEAR - RSSI_FAR;

  // Table contents after reset.
  localparam logic signed [7:0] RSSI_RESET = -8'sd127;

  // Division by the span is done as a multiply by a rounded-up reciprocal.
  // With this shift the result is exact for every product of a 12-bit
  // period difference and a 0..RSSI_SPAN offset.
  localparam int          FRAC_SHIFT = 24;
  localparam int          WEIGHT_W   = 25;
  localparam logic [24:0] FRAC_MULT  =
    25'((2 ** FRAC_SHIFT + RSSI_SPAN - 1) / RSSI_SPAN);

  // Configuration port geometry and register map.
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_TIMEOUT     = 3'd0;
  localparam logic [2:0] REG_HYSTERESIS  = 3'd1;
  localparam logic [2:0] REG_BEEP_ON     = 3'd2;
  localparam logic [2:0] REG_PERIOD_FAR  = 3'd3;
  localparam logic [2:0] REG_PERIOD_NEAR = 3'd4;

  // Register values after reset.
  localparam logic [15:0] TIMEOUT_RST     = 16'd5000;
  localparam logic [5:0]  HYSTERESIS_RST  = 6'd3;
  localparam logic [9:0]  BEEP_ON_RST     = 10'd80;
  localparam logic [11:0] PERIOD_FAR_RST  = 12'd1000;
  localparam logic [11:0] PERIOD_NEAR_RST = 12'd100;
  localparam logic [11:0] BEEP_PERIOD_RST = 12'd1000;

  // Request operations.
  typedef enum logic [1:0] {
    OP_SIGHTING = 2'd0,
    OP_EVALUATE = 2'd1,
    OP_SERVICE  = 2'd2
  } opcode_t;

  // Configuration register set as seen by the datapath.
  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [5:0]  hysteresis_db;
    logic [9:0]  tone_len_ms;
    logic [11:0] period_far_ms;
    logic [11:0] period_near_ms;
  } cfg_t;

endpackage

// ----- design/satb_cfg.sv -----
module satb_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [satb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output satb_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[satb_pkg::ADDR_W-1:2];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms     <= satb_pkg::TIMEOUT_RST;
      cfg.hysteresis_db  <= satb_pkg::HYSTERESIS_RST;
      cfg.tone_len_ms    <= satb_pkg::BEEP_ON_RST;
      cfg.period_far_ms  <= satb_pkg::PERIOD_FAR_RST;
      cfg.period_near_ms <= satb_pkg::PERIOD_NEAR_RST;
    end else if (wr_en) begin
      case (reg_sel)
        satb_pkg::REG_TIMEOUT:     cfg.timeout_ms     <= pwdata[15:0];
        satb_pkg::REG_HYSTERESIS:  cfg.hysteresis_db  <= pwdata[5:0];
        satb_pkg::REG_BEEP_ON:     cfg.tone_len_ms    <= pwdata[9:0];
        satb_pkg::REG_PERIOD_FAR:  cfg.period_far_ms  <= pwdata[11:0];
        satb_pkg::REG_PERIOD_NEAR: cfg.period_near_ms <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    case (reg_sel)
      satb_pkg::REG_TIMEOUT:     prdata = {16'b0, cfg.timeout_ms};
      satb_pkg::REG_HYSTERESIS:  prdata = {26'b0, cfg.hysteresis_db};
      satb_pkg::REG_BEEP_ON:     prdata = {22'b0, cfg.tone_len_ms};
      satb_pkg::REG_PERIOD_FAR:  prdata = {20'b0, cfg.period_far_ms};
      satb_pkg::REG_PERIOD_NEAR: prdata = {20'b0, cfg.period_near_ms};
      default:                   prdata = 32'b0;
    endcase
  end

endmodule

// ----- design/satb_period.sv -----
module satb_period (
  input  satb_pkg::cfg_t                cfg,
  input  logic [satb_pkg::WEIGHT_W-1:0] weight,
  output logic [11:0]                   period
);

  logic        far_ge;
  logic [11:0] diff;
  logic [36:0] prod;
  logic [11:0] step;
  logic [11:0] raw;
  logic [11:0] floor_ms;

  // The weight is the clamped RSSI offset already scaled by the reciprocal
  // of the span, so one multiply gives the interpolation step.
  always_comb begin
    far_ge   = cfg.period_far_ms >= cfg.period_near_ms;
    diff     = far_ge ? cfg.period_far_ms - cfg.period_near_ms
                      : cfg.period_near_ms - cfg.period_far_ms;
    prod     = {25'b0, diff} * {12'b0, weight};
    step     = prod[satb_pkg::FRAC_SHIFT +: 12];
    raw      = far_ge ? cfg.period_far_ms - step : cfg.period_far_ms + step;
    floor_ms = {2'b00, cfg.tone_len_ms};
    // The period never drops below the tone on time.
    period   = (raw < floor_ms) ? floor_ms : raw;
  end

endmodule

// ----- design/strongest_ap_tracker_beeper_top.sv -----
// A request accepted into the request register has its result registered in the
// result register when the request stage advances.
// Throughput: one request per cycle unless the result stalls; the tracking state
// is updated in the single stage between the request and result registers.
// The result register frees up whenever the downstream side takes its result.
// Reset is synchronous and active high: tables go to never seen at -127 dBm,
// no selection, beeper off, and the registers to their default values.
module strongest_ap_tracker_beeper_top #(
  parameter int NUM_APS = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  // Request channel
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  opcode,
  input  logic [31:0]                 now_ms,
  input  logic [1:0]                  ap_index,
  input  logic signed [7:0]           rssi_dbm,
  input  logic                        forced_valid,
  input  logic [1:0]                  forced_index,
  input  logic                        all_finished,
  input  logic                        link_busy,
  input  logic [2:0]                  done_mask,
  // Result channel
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic                        chosen_valid,
  output logic [1:0]                  chosen_index,
  output logic [2:0]                  led_mask,
  output logic                        tone_on,
  output logic [11:0]                 beep_period_ms,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [satb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef struct packed {
    satb_pkg::opcode_t opcode;
    logic [31:0]       now_ms;
    logic [1:0]        ap_index;
    logic signed [7:0] rssi_dbm;
    logic              forced_valid;
    logic [1:0]        forced_index;
    logic              all_finished;
    logic              link_busy;
    logic [2:0]        done_mask;
  } item_t;

  satb_pkg::cfg_t cfg;

  // Request register
  logic  s1_valid;
  item_t s1;
  logic  advance;

  // Tracking state
  logic signed [7:0]               rssi_table [NUM_APS];
  logic [31:0]                     seen_time  [NUM_APS];
  logic [satb_pkg::WEIGHT_W-1:0]   weight     [NUM_APS];
  logic                            sel_valid;
  logic [1:0]                      sel_index;
  logic [2:0]                      led_reg;
  logic                            beeper_enabled;
  logic                            beeper_on;
  logic [11:0]                     beep_period;
  logic [31:0]                     next_toggle_ms;

  // Next state
  logic                            sel_valid_next;
  logic [1:0]                      sel_index_next;
  logic [2:0]                      led_next;
  logic                            beeper_enabled_next;
  logic                            beeper_on_next;
  logic [11:0]                     beep_period_next;
  logic [31:0]                     next_toggle_ms_next;

  // Selection helpers
  logic [NUM_APS-1:0]              ap_ok;
  logic                            sel_ok;
  logic signed [7:0]               sel_rssi;
  logic                            found;
  logic [1:0]                      best_idx;
  logic signed [7:0]               best_rssi;
  logic signed [9:0]               best_ext;
  logic signed [9:0]               thresh;
  logic                            forced_ok;
  logic                            pick_ok;
  logic [satb_pkg::WEIGHT_W-1:0]   pick_weight;
  logic [11:0]                     pick_period;
  logic [31:0]                     due_diff;
  logic [11:0]                     on_ms;
  logic [11:0]                     off_ms;

  // Sighting weight
  logic signed [8:0]               rel;
  logic [5:0]                      ofs;
  logic [satb_pkg::WEIGHT_W-1:0]   new_weight;

  satb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  satb_period u_period (
    .cfg    (cfg),
    .weight (pick_weight),
    .period (pick_period)
  );

  // Pipeline flow: the request stage moves when the result register is free.
  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1.opcode       <= satb_pkg::opcode_t'(opcode);
      s1.now_ms       <= now_ms;
      s1.ap_index     <= ap_index;
      s1.rssi_dbm     <= rssi_dbm;
      s1.forced_valid <= forced_valid;
      s1.forced_index <= forced_index;
      s1.all_finished <= all_finished;
      s1.link_busy    <= link_busy;
      s1.done_mask    <= done_mask;
    end
  end

  // Clamp the sighting RSSI to the proximity window and prescale it.
  always_comb begin
    rel = 9'(s1.rssi_dbm) + 9'(-satb_pkg::RSSI_FAR);
    if (rel < 9'sd0) begin
      ofs = 6'd0;
    end else if (rel > 9'(satb_pkg::RSSI_SPAN)) begin
      ofs = 6'(satb_pkg::RSSI_SPAN);
    end else begin
      ofs = rel[5:0];
    end
    new_weight = 25'({19'b0, ofs} * satb_pkg::FRAC_MULT);
  end

  // Entry validity, current selection lookup and strongest valid entry.
  always_comb begin
    sel_ok    = 1'b0;
    sel_rssi  = satb_pkg::RSSI_RESET;
    found     = 1'b0;
    best_idx  = 2'b00;
    best_rssi = satb_pkg::RSSI_RESET;
    for (int i = 0; i < NUM_APS; i++) begin
      ap_ok[i] = (seen_time[i] != 32'b0) &&
                 ((s1.now_ms - seen_time[i]) < {16'b0, cfg.timeout_ms});
      if (int'(sel_index) == i) begin
        sel_ok   = ap_ok[i];
        sel_rssi = rssi_table[i];
      end
      if (ap_ok[i] && (!found || rssi_table[i] > best_rssi)) begin
        found     = 1'b1;
        best_idx  = 2'(i);
        best_rssi = rssi_table[i];
      end
    end
    best_ext  = {{2{best_rssi[7]}}, best_rssi};
    thresh    = {{2{sel_rssi[7]}}, sel_rssi} + {4'b0000, cfg.hysteresis_db};
    forced_ok = s1.forced_valid && (int'(s1.forced_index) < NUM_APS);
  end

  // Operation decode and next state.
  always_comb begin
    sel_valid_next      = sel_valid;
    sel_index_next      = sel_index;
    led_next            = led_reg;
    beeper_enabled_next = beeper_enabled;
    beeper_on_next      = beeper_on;
    beep_period_next    = beep_period;
    next_toggle_ms_next = next_toggle_ms;
    pick_ok             = 1'b0;
    pick_weight         = '0;
    on_ms               = {2'b00, cfg.tone_len_ms};
    off_ms              = (beep_period > on_ms) ? beep_period - on_ms : 12'd1;
    due_diff            = s1.now_ms - next_toggle_ms;

    // Selection per the rules when not finished.
    if (forced_ok) begin
      sel_valid_next = 1'b1;
      sel_index_next = s1.forced_index;
    end else if (!found) begin
      sel_valid_next = 1'b0;
      sel_index_next = 2'b00;
    end else if (!sel_valid || !sel_ok ||
                 (best_idx != sel_index && best_ext > thresh)) begin
      sel_valid_next = 1'b1;
      sel_index_next = best_idx;
    end

    // Signal weight of the resulting selection.
    for (int i = 0; i < NUM_APS; i++) begin
      if (int'(sel_index_next) == i) begin
        pick_ok     = ap_ok[i];
        pick_weight = weight[i];
      end
    end

    case (s1.opcode)
      satb_pkg::OP_EVALUATE: begin
        if (s1.all_finished) begin
          sel_valid_next      = 1'b0;
          sel_index_next      = 2'b00;
          led_next            = 3'b111;
          beeper_enabled_next = 1'b0;
          beeper_on_next      = 1'b0;
        end else begin
          led_next = s1.done_mask |
                     (sel_valid_next ? 3'(4'b0001 << sel_index_next) : 3'b000);
          if (!s1.link_busy) begin
            if (sel_valid_next && pick_ok) begin
              beep_period_next = pick_period;
              if (!beeper_enabled) begin
                beeper_enabled_next = 1'b1;
                beeper_on_next      = 1'b1;
                next_toggle_ms_next = s1.now_ms + {22'b0, cfg.tone_len_ms};
              end
            end else begin
              beeper_enabled_next = 1'b0;
              beeper_on_next      = 1'b0;
            end
          end
        end
      end
      satb_pkg::OP_SERVICE: begin
        sel_valid_next = sel_valid;
        sel_index_next = sel_index;
        if (s1.link_busy) begin
          beeper_enabled_next = 1'b0;
          beeper_on_next      = 1'b1;
        end else if (beeper_enabled && !due_diff[31]) begin
          if (beeper_on) begin
            beeper_on_next      = 1'b0;
            next_toggle_ms_next = s1.now_ms + {20'b0, off_ms};
          end else begin
            beeper_on_next      = 1'b1;
            next_toggle_ms_next = s1.now_ms + {22'b0, cfg.tone_len_ms};
          end
        end
      end
      default: begin
        // Sightings only touch the tables; the spare code changes nothing.
        sel_valid_next = sel_valid;
        sel_index_next = sel_index;
      end
    endcase
  end

  // Per access point tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_APS; i++) begin
        rssi_table[i] <= satb_pkg::RSSI_RESET;
        seen_time[i]  <= 32'b0;
        weight[i]     <= '0;
      end
    end else if (advance && s1.opcode == satb_pkg::OP_SIGHTING) begin
      for (int i = 0; i < NUM_APS; i++) begin
        if (int'(s1.ap_index) == i) begin
          rssi_table[i] <= s1.rssi_dbm;
          seen_time[i]  <= s1.now_ms;
          weight[i]     <= new_weight;
        end
      end
    end
  end

  // Selection and beeper state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid      <= 1'b0;
      sel_index      <= 2'b00;
      led_reg        <= 3'b000;
      beeper_enabled <= 1'b0;
      beeper_on      <= 1'b0;
      beep_period    <= satb_pkg::BEEP_PERIOD_RST;
      next_toggle_ms <= 32'b0;
    end else if (advance) begin
      sel_valid      <= sel_valid_next;
      sel_index      <= sel_index_next;
      led_reg        <= led_next;
      beeper_enabled <= beeper_enabled_next;
      beeper_on      <= beeper_on_next;
      beep_period    <= beep_period_next;
      next_toggle_ms <= next_toggle_ms_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      chosen_valid   <= sel_valid_next;
      chosen_index   <= sel_valid_next ? sel_index_next : 2'b00;
      led_mask       <= led_next;
      tone_on        <= beeper_on_next;
      beep_period_ms <= beep_period_next;
    end
  end

`ifndef SYNTHESIS
  // An accepted request always lands in the request stage.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> s1_valid)
    else $error("accepted request did not enter the request stage");

  // A stalled result holds the request stage in place.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && !rsp_ready |=> s1_valid)
    else $error("request stage dropped an item while the result was stalled");

  // Finished mode lights every LED and silences the tone.
  assert property (@(posedge clk) disable iff (rst)
    advance && s1.opcode == satb_pkg::OP_EVALUATE && s1.all_finished
    |=> led_mask == 3'b111 && !tone_on && !chosen_valid)
    else $error("finished evaluation did not give all LEDs and a silent buzzer");
`endif

endmodule
